// ===== rtl/tlvp_pkg.sv =====
// Package for the TLV frame parser: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

    localparam int unsigned FIELDS_PER_FRAME = 3;

    localparam logic [7:0]  HDR_BYTE0 = 8'd1;
    localparam logic [7:0]  HDR_BYTE1 = 8'd0;
    localparam logic [15:0] MIN_TOTAL = 16'd9;
    localparam logic [7:0]  TAG_MAX   = 8'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_SHORT  = 2'd2;
    localparam logic [1:0] ERR_TAG    = 2'd3;

    typedef enum logic [8:0] {
        PH_HDR0    = 9'b000000001,
        PH_HDR1    = 9'b000000010,
        PH_TLEN_HI = 9'b000000100,
        PH_TLEN_LO = 9'b000001000,
        PH_TAG     = 9'b000010000,
        PH_FLEN_HI = 9'b000100000,
        PH_FLEN_LO = 9'b001000000,
        PH_PAYLOAD = 9'b010000000,
        PH_DISCARD = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic       has_data;
        logic [1:0] field_kind;
        logic [7:0] data_byte;
        logic       field_last;
        logic       frame_done;
        logic [1:0] error_code;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/tlvp_if.sv =====
// Valid/ready stream interfaces for the TLV frame parser input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface tlvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       frame_start;

    modport source (output valid, output byte_in, output frame_start, input ready);
    modport sink   (input valid, input byte_in, input frame_start, output ready);
endinterface

interface tlvp_out_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic [1:0] field_kind;
    logic [7:0] data_byte;
    logic       field_last;
    logic       frame_done;
    logic [1:0] error_code;

    modport source (output valid, output has_data, output field_kind, output data_byte,
                    output field_last, output frame_done, output error_code, input ready);
    modport sink   (input valid, input has_data, input field_kind, input data_byte,
                    input field_last, input frame_done, input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/tlv_message_frame_parser_unit.sv =====
// TLV message frame parser top level: byte-serial parse with a two-slot result buffer.
//
// Takes one stream byte per clock while ready and returns at most one result word per
// byte. The word is written into the head register as its byte is accepted, or into the
// skid slot while earlier results wait. The parse state update and result formation are one
// short step between the phase/length registers and the result register, so the byte rate is
// one per cycle. Results sit in a head register backed by one skid slot: input stays ready
// while one result waits, and drops only when both slots hold untaken results.
`timescale 1ns / 1ps
`default_nettype none

module tlv_message_frame_parser_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tlvp_in_if.sink     i_in,
    tlvp_out_if.source  o_out
);

    tlvp_pkg::t_phase    r_phase, n_phase;
    logic [1:0]          r_fnum, n_fnum;
    logic [15:0]         r_rem, n_rem;
    logic [7:0]          r_hold, n_hold;
    logic [1:0]          r_kind, n_kind;

    tlvp_pkg::t_out_word r_out, r_skd, res;
    logic                r_out_valid, r_skd_valid;
    logic                res_vld;

    tlvp_pkg::t_phase    phase_cur;
    logic [1:0]          fnum_cur;
    logic [15:0]         len;
    logic                last_field;
    logic                accept, push, pop;

    assign accept = i_in.valid && i_in.ready;
    assign pop    = o_out.valid && o_out.ready;
    assign push   = accept && res_vld;

    assign i_in.ready = !r_skd_valid;

    assign phase_cur  = i_in.frame_start ? tlvp_pkg::PH_HDR0 : r_phase;
    assign fnum_cur   = i_in.frame_start ? 2'd0 : r_fnum;
    assign len        = {r_hold, i_in.byte_in};
    assign last_field = ({1'b0, fnum_cur} + 3'd1) >= 3'(tlvp_pkg::FIELDS_PER_FRAME);

    always_comb begin
        n_phase = phase_cur;
        n_fnum  = fnum_cur;
        n_rem   = r_rem;
        n_hold  = r_hold;
        n_kind  = r_kind;
        res_vld = 1'b0;
        res     = '0;
        case (phase_cur)
            tlvp_pkg::PH_HDR0: begin
                if (i_in.byte_in != tlvp_pkg::HDR_BYTE0) begin
                    res_vld        = 1'b1;
                    res.error_code = tlvp_pkg::ERR_HEADER;
                    n_phase        = tlvp_pkg::PH_DISCARD;
                end else begin
                    n_phase = tlvp_pkg::PH_HDR1;
                end
            end
            tlvp_pkg::PH_HDR1: begin
                if (i_in.byte_in != tlvp_pkg::HDR_BYTE1) begin
                    res_vld        = 1'b1;
                    res.error_code = tlvp_pkg::ERR_HEADER;
                    n_phase        = tlvp_pkg::PH_DISCARD;
                end else begin
                    n_phase = tlvp_pkg::PH_TLEN_HI;
                end
            end
            tlvp_pkg::PH_TLEN_HI: begin
                n_hold  = i_in.byte_in;
                n_phase = tlvp_pkg::PH_TLEN_LO;
            end
            tlvp_pkg::PH_TLEN_LO: begin
                if (len <= tlvp_pkg::MIN_TOTAL) begin
                    res_vld        = 1'b1;
                    res.error_code = tlvp_pkg::ERR_SHORT;
                    n_phase        = tlvp_pkg::PH_DISCARD;
                end else begin
                    n_fnum  = 2'd0;
                    n_phase = tlvp_pkg::PH_TAG;
                end
            end
            tlvp_pkg::PH_TAG: begin
                if (i_in.byte_in > tlvp_pkg::TAG_MAX) begin
                    res_vld        = 1'b1;
                    res.error_code = tlvp_pkg::ERR_TAG;
                    n_phase        = tlvp_pkg::PH_DISCARD;
                end else begin
                    n_kind  = i_in.byte_in[1:0];
                    n_phase = tlvp_pkg::PH_FLEN_HI;
                end
            end
            tlvp_pkg::PH_FLEN_HI: begin
                n_hold  = i_in.byte_in;
                n_phase = tlvp_pkg::PH_FLEN_LO;
            end
            tlvp_pkg::PH_FLEN_LO: begin
                if (len == 16'd0) begin
                    // empty field: report it on its low length byte
                    res_vld        = 1'b1;
                    res.field_kind = r_kind;
                    res.field_last = 1'b1;
                    res.frame_done = last_field;
                    n_rem          = 16'd0;
                    n_fnum         = last_field ? 2'd0 : fnum_cur + 2'd1;
                    n_phase        = last_field ? tlvp_pkg::PH_HDR0 : tlvp_pkg::PH_TAG;
                end else begin
                    n_rem   = len;
                    n_phase = tlvp_pkg::PH_PAYLOAD;
                end
            end
            tlvp_pkg::PH_PAYLOAD: begin
                res_vld        = 1'b1;
                res.has_data   = 1'b1;
                res.field_kind = r_kind;
                res.data_byte  = i_in.byte_in;
                if (r_rem <= 16'd1) begin
                    res.field_last = 1'b1;
                    res.frame_done = last_field;
                    n_rem          = 16'd0;
                    n_fnum         = last_field ? 2'd0 : fnum_cur + 2'd1;
                    n_phase        = last_field ? tlvp_pkg::PH_HDR0 : tlvp_pkg::PH_TAG;
                end else begin
                    n_rem = r_rem - 16'd1;
                end
            end
            default: begin
                n_phase = tlvp_pkg::PH_DISCARD;
            end
        endcase
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlvp_pkg::PH_HDR0;
            r_fnum  <= 2'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_fnum  <= n_fnum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rem  <= n_rem;
            r_hold <= n_hold;
            r_kind <= n_kind;
        end
    end

    // result head register plus skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (r_skd_valid) begin
                if (pop) begin
                    r_skd_valid <= 1'b0;
                end
            end else if (push && r_out_valid && !pop) begin
                r_skd_valid <= 1'b1;
            end else if (push) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (push && r_out_valid && !pop) begin
            r_skd <= res;
        end else if (push) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.has_data   = r_out.has_data;
    assign o_out.field_kind = r_out.field_kind;
    assign o_out.data_byte  = r_out.data_byte;
    assign o_out.field_last = r_out.field_last;
    assign o_out.frame_done = r_out.frame_done;
    assign o_out.error_code = r_out.error_code;

endmodule

`default_nettype wire

// ===== rtl/tlvp_checker.sv =====
// Port-level checker for the TLV frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_has_data,
    input wire logic [1:0] i_field_kind,
    input wire logic [7:0] i_data_byte,
    input wire logic       i_field_last,
    input wire logic       i_frame_done,
    input wire logic [1:0] i_error_code
);

    // error words carry nothing but the code
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_error_code != tlvp_pkg::ERR_NONE) |->
        !i_has_data && !i_field_last && !i_frame_done && (i_field_kind == 2'd0)
        && (i_data_byte == 8'd0))
        else $error("error word carries payload bits");

    // a word without data or error can only be an empty field
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_data && (i_error_code == tlvp_pkg::ERR_NONE) |->
        i_field_last && (i_data_byte == 8'd0))
        else $error("dataless word is not an empty field end");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_field_last)
        else $error("frame end without field end");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_error_code == tlvp_pkg::ERR_NONE) |-> (i_field_kind != 2'd3))
        else $error("field kind out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
        && $stable(i_error_code) && $stable(i_field_last))
        else $error("stalled result word changed");

endmodule

bind tlv_message_frame_parser_unit tlvp_checker u_tlvp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_has_data   (o_out.has_data),
    .i_field_kind (o_out.field_kind),
    .i_data_byte  (o_out.data_byte),
    .i_field_last (o_out.field_last),
    .i_frame_done (o_out.frame_done),
    .i_error_code (o_out.error_code)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the TLV message frame parser: directed rows, then random frames.
`timescale 1ns / 1ps

module tb;
    import tlvp_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1150;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned DIR_N        = 31;

    localparam logic [1:0] KIND_RCPT  = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd2;
    localparam logic [7:0] TAG_RCPT   = 8'd0;
    localparam logic [7:0] TAG_SENDER = 8'd1;
    localparam logic [7:0] TAG_TEXT   = 8'd2;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_RESULT, ROW_TYPED} t_row_chk;

    typedef struct packed {
        logic [7:0] b;
        logic       sof;
        t_row_chk   chk;
        t_out_word  word;
    } t_row;

    localparam t_out_word W_NIL = '0;
    localparam t_out_word W_BAD_HDR = '{has_data: 1'b0, field_kind: 2'd0, data_byte: 8'h00,
                                        field_last: 1'b0, frame_done: 1'b0,
                                        error_code: ERR_HEADER};
    localparam t_out_word W_SHORT = '{has_data: 1'b0, field_kind: 2'd0, data_byte: 8'h00,
                                      field_last: 1'b0, frame_done: 1'b0,
                                      error_code: ERR_SHORT};
    localparam t_out_word W_BAD_TAG = '{has_data: 1'b0, field_kind: 2'd0, data_byte: 8'h00,
                                        field_last: 1'b0, frame_done: 1'b0,
                                        error_code: ERR_TAG};
    localparam t_out_word W_EMPTY_RCPT = '{has_data: 1'b0, field_kind: KIND_RCPT,
                                           data_byte: 8'h00, field_last: 1'b1,
                                           frame_done: 1'b0, error_code: ERR_NONE};
    localparam t_out_word W_RCPT_FF = '{has_data: 1'b1, field_kind: KIND_RCPT,
                                        data_byte: 8'hFF, field_last: 1'b1,
                                        frame_done: 1'b0, error_code: ERR_NONE};
    localparam t_out_word W_TEXT_END = '{has_data: 1'b0, field_kind: KIND_TEXT,
                                         data_byte: 8'h00, field_last: 1'b1,
                                         frame_done: 1'b1, error_code: ERR_NONE};

    localparam t_row DIR_ROWS [DIR_N] = '{
        // no frame start after reset: taken as the first header byte
        '{8'h05,      1'b0, ROW_TYPED,     W_BAD_HDR},
        '{HDR_BYTE0,  1'b1, ROW_NO_RESULT, W_NIL},
        '{8'hFF,      1'b0, ROW_TYPED,     W_BAD_HDR},
        // total length 9 is one short of the minimum
        '{HDR_BYTE0,  1'b1, ROW_NO_RESULT, W_NIL},
        '{HDR_BYTE1,  1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h00,      1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h09,      1'b0, ROW_TYPED,     W_SHORT},
        // max total length, empty field, repeated tag, one-byte field, empty last field
        '{HDR_BYTE0,  1'b1, ROW_NO_RESULT, W_NIL},
        '{HDR_BYTE1,  1'b0, ROW_NO_RESULT, W_NIL},
        '{8'hFF,      1'b0, ROW_NO_RESULT, W_NIL},
        '{8'hFF,      1'b0, ROW_NO_RESULT, W_NIL},
        '{TAG_RCPT,   1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h00,      1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h00,      1'b0, ROW_TYPED,     W_EMPTY_RCPT},
        '{TAG_RCPT,   1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h00,      1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h01,      1'b0, ROW_NO_RESULT, W_NIL},
        '{8'hFF,      1'b0, ROW_TYPED,     W_RCPT_FF},
        '{TAG_TEXT,   1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h00,      1'b0, ROW_NO_RESULT, W_NIL},
        '{8'h00,      1'b0, ROW_TYPED,     W_TEXT_END},
        // next frame without frame start, smallest valid total, abandoned mid-frame
        '{HDR_BYTE0,  1'b0, ROW_PREDICT,   W_NIL},
        '{HDR_BYTE1,  1'b0, ROW_PREDICT,   W_NIL},
        '{8'h00,      1'b0, ROW_PREDICT,   W_NIL},
        '{8'h0A,      1'b0, ROW_PREDICT,   W_NIL},
        '{TAG_SENDER, 1'b0, ROW_PREDICT,   W_NIL},
        '{HDR_BYTE0,  1'b1, ROW_PREDICT,   W_NIL},
        '{HDR_BYTE1,  1'b0, ROW_PREDICT,   W_NIL},
        '{8'h00,      1'b0, ROW_PREDICT,   W_NIL},
        '{8'h20,      1'b0, ROW_PREDICT,   W_NIL},
        '{8'hFF,      1'b0, ROW_TYPED,     W_BAD_TAG}
    };

    logic i_clk;
    logic i_rst_n;

    tlvp_in_if  in_if ();
    tlvp_out_if out_if ();

    tlv_message_frame_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // parser state as predicted from the accepted bytes
    t_phase      pp_phase;
    int unsigned pp_field;
    logic [15:0] pp_remain;
    logic [7:0]  pp_len_hi;
    logic [1:0]  pp_kind;

    t_out_word   results_due [$];
    int unsigned mismatches    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned src_idle_pct  = 30;
    int unsigned sink_idle_pct = 71;
    int unsigned cycle_cnt     = 0;

    function automatic void parser_clear();
        pp_phase  = PH_HDR0;
        pp_field  = 0;
        pp_remain = '0;
        pp_len_hi = '0;
        pp_kind   = '0;
    endfunction

    // returns the frame-done mark
    function automatic logic close_field();
        logic last_one;
        last_one  = (pp_field + 1) >= FIELDS_PER_FRAME;
        pp_remain = '0;
        if (last_one) begin
            pp_field = 0;
            pp_phase = PH_HDR0;
        end else begin
            pp_field = pp_field + 1;
            pp_phase = PH_TAG;
        end
        return last_one;
    endfunction

    function automatic logic parse_frame_byte(input logic [7:0] b, input logic sof,
                                              output t_out_word w);
        logic [15:0] len;
        logic        emits;
        w     = '0;
        emits = 1'b0;
        if (sof) parser_clear();
        len = {pp_len_hi, b};
        case (pp_phase)
            PH_HDR0: begin
                if (b != HDR_BYTE0) begin
                    w.error_code = ERR_HEADER;
                    pp_phase     = PH_DISCARD;
                    emits        = 1'b1;
                end else begin
                    pp_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                if (b != HDR_BYTE1) begin
                    w.error_code = ERR_HEADER;
                    pp_phase     = PH_DISCARD;
                    emits        = 1'b1;
                end else begin
                    pp_phase = PH_TLEN_HI;
                end
            end
            PH_TLEN_HI: begin
                pp_len_hi = b;
                pp_phase  = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
                if (len <= MIN_TOTAL) begin
                    w.error_code = ERR_SHORT;
                    pp_phase     = PH_DISCARD;
                    emits        = 1'b1;
                end else begin
                    pp_field = 0;
                    pp_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                if (b > TAG_MAX) begin
                    w.error_code = ERR_TAG;
                    pp_phase     = PH_DISCARD;
                    emits        = 1'b1;
                end else begin
                    pp_kind  = b[1:0];
                    pp_phase = PH_FLEN_HI;
                end
            end
            PH_FLEN_HI: begin
                pp_len_hi = b;
                pp_phase  = PH_FLEN_LO;
            end
            PH_FLEN_LO: begin
                if (len == 16'd0) begin
                    // empty field reports on its low length byte
                    w.field_kind = pp_kind;
                    w.field_last = 1'b1;
                    w.frame_done = close_field();
                    emits        = 1'b1;
                end else begin
                    pp_remain = len;
                    pp_phase  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w.has_data   = 1'b1;
                w.field_kind = pp_kind;
                w.data_byte  = b;
                emits        = 1'b1;
                if (pp_remain <= 16'd1) begin
                    w.field_last = 1'b1;
                    w.frame_done = close_field();
                end else begin
                    pp_remain = pp_remain - 16'd1;
                end
            end
            default: pp_phase = PH_DISCARD;
        endcase
        return emits;
    endfunction

    function automatic string fmt_word(input t_out_word w);
        return $sformatf("data=%0d kind=%0d byte=%02h last=%0d done=%0d err=%0d",
                         w.has_data, w.field_kind, w.data_byte, w.field_last,
                         w.frame_done, w.error_code);
    endfunction

    function automatic void note_mismatch(input string msg);
        if (mismatches < 10) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
        mismatches++;
    endfunction

    // drive one byte, wait for it to be taken, then predict its result
    task automatic push_byte(input logic [7:0] b, input logic sof, input t_row_chk chk,
                             input t_out_word typed);
        t_out_word w;
        logic      emits;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.byte_in     <= b;
        in_if.frame_start <= sof;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        emits = parse_frame_byte(b, sof, w);
        if (chk == ROW_TYPED) begin
            results_due.push_back(typed);
        end else if (chk == ROW_PREDICT && emits) begin
            results_due.push_back(w);
        end
        bytes_sent++;
    endtask

    task automatic random_frame();
        logic [7:0]  frame [$];
        logic [15:0] flen;
        logic        sof;
        int unsigned roll;
        int unsigned cut;
        int unsigned f;
        int unsigned i;
        roll = $urandom_range(99);
        // after a completed frame the parser accepts a header without frame start
        sof  = !(pp_phase == PH_HDR0 && $urandom_range(3) == 0);
        if (roll < 8) begin
            repeat ($urandom_range(6, 1)) begin
                push_byte(8'($urandom), $urandom_range(7) == 0, ROW_PREDICT, W_NIL);
            end
            return;
        end
        frame.push_back(roll < 11 ? 8'($urandom) : HDR_BYTE0);
        frame.push_back((roll >= 11 && roll < 14) ? 8'($urandom) : HDR_BYTE1);
        if (roll >= 14 && roll < 20) begin
            flen = 16'($urandom_range(9));
        end else begin
            flen = 16'($urandom_range(65535, 10));
        end
        frame.push_back(flen[15:8]);
        frame.push_back(flen[7:0]);
        for (f = 0; f < FIELDS_PER_FRAME; f++) begin
            if ($urandom_range(49) == 0) begin
                frame.push_back(8'($urandom_range(255, 3)));
            end else begin
                frame.push_back(8'($urandom_range(2)));
            end
            if ($urandom_range(119) == 0) begin
                flen = 16'($urandom_range(264, 256));
            end else begin
                flen = 16'($urandom_range(6));
            end
            frame.push_back(flen[15:8]);
            frame.push_back(flen[7:0]);
            repeat (flen) frame.push_back(8'($urandom));
        end
        cut = frame.size();
        if ($urandom_range(19) == 0) cut = $urandom_range(frame.size() - 1, 1);
        for (i = 0; i < cut; i++) begin
            push_byte(frame[i], (i == 0) ? sof : 1'b0, ROW_PREDICT, W_NIL);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{has_data: out_if.has_data, field_kind: out_if.field_kind,
                    data_byte: out_if.data_byte, field_last: out_if.field_last,
                    frame_done: out_if.frame_done, error_code: out_if.error_code};
            if (results_due.size() == 0) begin
                note_mismatch({"unexpected result ", fmt_word(got)});
            end else begin
                want = results_due.pop_front();
                if (got.has_data !== want.has_data || got.field_kind !== want.field_kind ||
                    got.data_byte !== want.data_byte || got.field_last !== want.field_last ||
                    got.frame_done !== want.frame_done ||
                    got.error_code !== want.error_code) begin
                    note_mismatch({"got ", fmt_word(got), " expected ", fmt_word(want)});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tlv_message_frame_parser_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.byte_in     <= 8'h00;
        in_if.frame_start <= 1'b0;
        parser_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_N; r++) begin
            push_byte(DIR_ROWS[r].b, DIR_ROWS[r].sof, DIR_ROWS[r].chk, DIR_ROWS[r].word);
        end

        while (bytes_sent < DIR_N + RANDOM_BYTES) begin
            if (bytes_sent - DIR_N < RANDOM_BYTES / 3) begin
                src_idle_pct  = 30;
                sink_idle_pct = 71;
            end else if (bytes_sent - DIR_N < 2 * RANDOM_BYTES / 3) begin
                src_idle_pct  = 71;
                sink_idle_pct = 30;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            random_frame();
        end
        in_if.valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tlv_message_frame_parser_unit: match");
        end else begin
            $display("tlv_message_frame_parser_unit: mismatch");
        end
        $finish;
    end

endmodule
